FILE: rtl/sliding_window_call_rate_limiter_macros.svh
// Assertion helpers shared by the RTL; every use samples on clk and
// is disabled while rst_n is low.
`ifndef SLIDING_WINDOW_CALL_RATE_LIMITER_MACROS_SVH
`define SLIDING_WINDOW_CALL_RATE_LIMITER_MACROS_SVH

// Property must hold at every sampled edge.
`define SWRL_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: %m");

// Consequent must hold in the cycle after the antecedent.
`define SWRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

FILE: rtl/swrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swrl_pkg;

    // Window length and log depth; FIFO_DEPTH is a power of two.
    localparam int WINDOW_SECONDS = 5;
    localparam int FIFO_DEPTH     = 1024;

    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int TIME_W  = 48;
    localparam int CMD_W   = 2;
    localparam int PCT_W   = 10;
    localparam int RATE_W  = 11;
    localparam int LIMIT_W = 16;

    localparam int RATE_MAX  = 2047;
    localparam int LIMIT_MAX = 65535;

    localparam logic [TIME_W-1:0] WINDOW_US = TIME_W'(WINDOW_SECONDS * 1000000);

    // count / WINDOW_SECONDS as a multiply by a rounded-up reciprocal
    localparam int RATE_SHIFT = CNT_W + 7;
    localparam int RMUL_W     = RATE_SHIFT + 1;
    localparam logic [63:0] RATE_MUL =
        ((64'd1 << RATE_SHIFT) + 64'(WINDOW_SECONDS) - 64'd1) / 64'(WINDOW_SECONDS);
    localparam int RPROD_W    = CNT_W + RMUL_W;
    localparam int RQ_W       = RPROD_W - RATE_SHIFT;

    // percent * count / (100 * WINDOW_SECONDS), same reciprocal scheme
    localparam int LIM_DIV   = 100 * WINDOW_SECONDS;
    localparam int PROD_W    = PCT_W + CNT_W;
    localparam int LIM_SHIFT = PROD_W + 13;
    localparam int LMUL_W    = LIM_SHIFT - 6;
    localparam logic [63:0] LIM_MUL =
        ((64'd1 << LIM_SHIFT) + 64'(LIM_DIV) - 64'd1) / 64'(LIM_DIV);
    localparam int LPROD_W   = PROD_W + LMUL_W;
    localparam int LQ_W      = LPROD_W - LIM_SHIFT;

    localparam logic [CMD_W-1:0] CMD_ATTEMPT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SOFT      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_PEAK = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/sliding_window_call_rate_limiter.sv
`timescale 1ns / 1ps
`default_nettype none

// Call admission limiter over a sliding window of admitted arrival times.
// Each input word (cmd, now_us, percent) first drops log entries at least
// WINDOW_SECONDS old, then attempts a call, applies a soft limit or reads
// and clears the peak rate, and yields one result word. An item passes
// through S_CHECK, S_MUL and S_DIV to S_ACT, which waits for a free output;
// in S_CHECK the expiry loop pops one entry per cycle through the
// single read port of the arrival-time memory, and the rate and soft-limit
// quotients come from two registered reciprocal multiplies. in_stall stays
// high while an item is in work. The memory needs no clearing after reset.
// hard_limit is written through cfg_valid/cfg_ready and also sets the
// active limit; write it only while the block is idle.
`include "sliding_window_call_rate_limiter_macros.svh"

module sliding_window_call_rate_limiter
    import swrl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [LIMIT_W-1:0]  hard_limit,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [TIME_W-1:0]   now_us,
    input  wire logic [PCT_W-1:0]    percent,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     rejected,
    output logic [RATE_W-1:0]        avg_rate,
    output logic [RATE_W-1:0]        peak_rate,
    output logic [LIMIT_W-1:0]       active_limit_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ACT   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0] active_reg, active_next;
    logic [LIMIT_W-1:0] hard_reg, hard_next;
    logic [RATE_W-1:0]  peak_reg, peak_next;
    logic               out_valid_reg, out_valid_next;

    logic [CMD_W-1:0]   cmd_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [PCT_W-1:0]   percent_reg;

    logic [TIME_W-1:0]  mem [FIFO_DEPTH];
    logic [TIME_W-1:0]  rd_data_reg;
    logic [PTR_W-1:0]   rd_addr;
    logic               mem_we;

    logic [RPROD_W-1:0] rate_prod_reg;
    logic [PROD_W-1:0]  pct_prod_reg;
    logic [LPROD_W-1:0] lim_prod_reg;
    logic [RATE_W-1:0]  rate_reg;

    logic               rejected_reg, rejected_next;
    logic [RATE_W-1:0]  avg_reg;
    logic [RATE_W-1:0]  peak_out_reg, peak_out_next;
    logic [LIMIT_W-1:0] limit_out_reg;

    logic               in_accept;
    logic               out_free;
    logic [TIME_W-1:0]  age;
    logic               expired;
    logic               pop;
    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W:0]     tail_sum;
    logic [PTR_W-1:0]   tail_idx;
    logic [RQ_W-1:0]    rate_q;
    logic [RATE_W-1:0]  rate_sat;
    logic [LQ_W-1:0]    lim_q;
    logic [LIMIT_W-1:0] soft_limit;
    logic               over_limit;
    logic               fifo_full;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign age      = now_reg - rd_data_reg;
    assign expired  = (age >= WINDOW_US);
    assign pop      = (state_reg == S_CHECK) && (count_reg != '0) && expired;
    assign head_inc = (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Prefetch the next head while popping so one entry retires per cycle.
    assign rd_addr = (state_reg == S_CHECK) ? head_inc : head_reg;

    assign tail_sum = {1'b0, head_reg} + {1'b0, count_reg[PTR_W-1:0]};
    assign tail_idx = (tail_sum >= (PTR_W+1)'(FIFO_DEPTH))
                    ? PTR_W'(tail_sum - (PTR_W+1)'(FIFO_DEPTH))
                    : tail_sum[PTR_W-1:0];

    assign rate_q   = rate_prod_reg[RPROD_W-1:RATE_SHIFT];
    assign rate_sat = (32'(rate_q) > 32'(RATE_MAX)) ? RATE_W'(RATE_MAX) : RATE_W'(rate_q);

    assign lim_q = lim_prod_reg[LPROD_W-1:LIM_SHIFT];
    always_comb
    begin
        if (32'(lim_q) > 32'(LIMIT_MAX))
            soft_limit = LIMIT_W'(LIMIT_MAX);
        else if (lim_q == '0)
            soft_limit = LIMIT_W'(1);
        else
            soft_limit = LIMIT_W'(lim_q);
    end

    assign over_limit = (active_reg != '0) && (32'(rate_reg) > 32'(active_reg));
    assign fifo_full  = (32'(count_reg) >= 32'(FIFO_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        hard_next      = hard_reg;
        peak_next      = peak_reg;
        out_valid_next = out_valid_reg;
        rejected_next  = 1'b0;
        peak_out_next  = peak_reg;
        mem_we         = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            hard_next   = hard_limit;
            active_next = hard_limit;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (pop)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
                state_next = S_DIV;
            S_DIV:
                state_next = S_ACT;
            S_ACT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    case (cmd_reg)
                        CMD_ATTEMPT:
                        begin
                            if (rate_reg > peak_reg)
                                peak_next = rate_reg;
                            if (over_limit || fifo_full)
                                rejected_next = 1'b1;
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            peak_out_next = peak_next;
                        end
                        CMD_SOFT:
                        begin
                            active_next = (percent_reg == '0) ? hard_reg : soft_limit;
                        end
                        CMD_READ_PEAK:
                        begin
                            peak_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            active_reg    <= '0;
            hard_reg      <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            hard_reg      <= hard_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg     <= cmd;
            now_reg     <= now_us;
            percent_reg <= percent;
        end
        if (state_reg == S_MUL)
        begin
            rate_prod_reg <= RPROD_W'(count_reg) * RPROD_W'(RATE_MUL);
            pct_prod_reg  <= PROD_W'(percent_reg) * PROD_W'(count_reg);
        end
        if (state_reg == S_DIV)
        begin
            rate_reg     <= rate_sat;
            lim_prod_reg <= LPROD_W'(pct_prod_reg) * LPROD_W'(LIM_MUL);
        end
        if ((state_reg == S_ACT) && out_free)
        begin
            rejected_reg  <= rejected_next;
            avg_reg       <= rate_reg;
            peak_out_reg  <= peak_out_next;
            limit_out_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[tail_idx] <= now_reg;
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid        = out_valid_reg;
    assign rejected         = rejected_reg;
    assign avg_rate         = avg_reg;
    assign peak_rate        = peak_out_reg;
    assign active_limit_out = limit_out_reg;

    `SWRL_ASSERT_ALWAYS(a_count_bound, 32'(count_reg) <= 32'(FIFO_DEPTH))
    `SWRL_ASSERT_NEXT(a_accept_starts_expiry, in_accept, state_reg == S_CHECK)
    `SWRL_ASSERT_NEXT(a_pop_decrements, pop, count_reg == $past(count_reg) - 1'b1)
    `SWRL_ASSERT_ALWAYS(a_push_not_full, !mem_we || (32'(count_reg) < 32'(FIFO_DEPTH)))

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import swrl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;

    localparam int DRAIN_CYCLES = FIFO_DEPTH + 64;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        logic [CMD_W-1:0]  c;
        logic [TIME_W-1:0] t;
        logic [PCT_W-1:0]  pct;
    } call_t;

    typedef struct packed {
        logic               rejected;
        logic [RATE_W-1:0]  avg;
        logic [RATE_W-1:0]  peak;
        logic [LIMIT_W-1:0] limit;
    } verdict_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  hard_limit = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd = '0;
    logic [TIME_W-1:0]   now_us = '0;
    logic [PCT_W-1:0]    percent = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                rejected;
    logic [RATE_W-1:0]   avg_rate;
    logic [RATE_W-1:0]   peak_rate;
    logic [LIMIT_W-1:0]  active_limit_out;

    sliding_window_call_rate_limiter i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .hard_limit       (hard_limit),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .now_us           (now_us),
        .percent          (percent),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .rejected         (rejected),
        .avg_rate         (avg_rate),
        .peak_rate        (peak_rate),
        .active_limit_out (active_limit_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow copy of the limiter state
    logic [TIME_W-1:0] log_times [0:FIFO_DEPTH-1];
    int                log_head = 0;
    int                log_count = 0;
    int                limit_now = 0;
    int                hard_now = 0;
    int                peak_seen = 0;

    call_t    call_q [$];
    verdict_t outcome_q [$];
    int       calls_queued = 0;
    int       calls_taken = 0;
    int       fail_count = 0;
    int       hold_asked = 0;
    int       hold_served = 0;

    function automatic verdict_t admission_outcome(input logic [CMD_W-1:0] c,
                                                   input logic [TIME_W-1:0] t,
                                                   input logic [PCT_W-1:0] pct);
        verdict_t          v;
        int                rate;
        longint            soft_lim;
        logic [TIME_W-1:0] age;
        v = '0;
        // drop entries at least one window old; age wraps at the field width
        while (log_count > 0)
        begin
            age = t - log_times[log_head];
            if (age < WINDOW_US)
                break;
            log_head = (log_head + 1) % FIFO_DEPTH;
            log_count--;
        end
        rate = log_count / WINDOW_SECONDS;
        if (rate > RATE_MAX)
            rate = RATE_MAX;
        v.avg = RATE_W'(rate);
        if (c == CMD_ATTEMPT)
        begin
            if (rate > peak_seen)
                peak_seen = rate;
            if (limit_now != 0 && rate > limit_now)
                v.rejected = 1'b1;
            else if (log_count >= FIFO_DEPTH)
                v.rejected = 1'b1;
            else
            begin
                log_times[(log_head + log_count) % FIFO_DEPTH] = t;
                log_count++;
            end
            v.peak = RATE_W'(peak_seen);
        end
        else if (c == CMD_SOFT)
        begin
            if (pct == '0)
                limit_now = hard_now;
            else
            begin
                soft_lim = (longint'(pct) * log_count) / (100 * WINDOW_SECONDS);
                if (soft_lim > LIMIT_MAX)
                    soft_lim = LIMIT_MAX;
                if (soft_lim == 0)
                    soft_lim = 1;
                limit_now = int'(soft_lim);
            end
            v.peak = RATE_W'(peak_seen);
        end
        else if (c == CMD_READ_PEAK)
        begin
            v.peak = RATE_W'(peak_seen);
            peak_seen = 0;
        end
        else
            v.peak = RATE_W'(peak_seen);
        v.limit = LIMIT_W'(limit_now);
        return v;
    endfunction

    // driver: words go out in bursts; a stalled word is held
    int    burst_left = 1;
    int    gap_left = 0;
    call_t next_call;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                outcome_q.push_back(admission_outcome(cmd, now_us, percent));
                calls_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (call_q.size() != 0)
                begin
                    next_call = call_q.pop_front();
                    in_valid <= 1'b1;
                    cmd <= next_call.c;
                    now_us <= next_call.t;
                    percent <= next_call.pct;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with an occasional long hold on request
    int stall_mode = STALL_NONE;
    int mode_left = 0;
    int hold_left = 0;
    int beat = 0;

    always @(posedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
                mode_left = $urandom_range(20, 150);
            end
            else
                mode_left--;
            beat++;
            case (stall_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_RANDOM: out_stall <= ($urandom_range(0, 1) == 1);
                default:      out_stall <= (beat % 4 == 0);
            endcase
        end
    end

    // monitor: compare each result word with the oldest prediction
    verdict_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (outcome_q.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: result word with nothing pending:", $realtime,
                             " rej=%0d avg=%0d peak=%0d lim=%0d",
                             rejected, avg_rate, peak_rate, active_limit_out);
                fail_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (rejected !== want.rejected || avg_rate !== want.avg ||
                    peak_rate !== want.peak || active_limit_out !== want.limit)
                begin
                    if (fail_count < 10)
                        $display("%0t: mismatch", $realtime,
                                 " exp rej=%0d avg=%0d peak=%0d lim=%0d",
                                 want.rejected, want.avg, want.peak, want.limit,
                                 " got rej=%0d avg=%0d peak=%0d lim=%0d",
                                 rejected, avg_rate, peak_rate, active_limit_out);
                    fail_count++;
                end
            end
        end
    end

    task automatic offer(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                         input logic [PCT_W-1:0] pct);
        call_t w;
        w.c = c;
        w.t = t;
        w.pct = pct;
        call_q.push_back(w);
        calls_queued++;
    endtask

    task automatic wait_drained(input int extra);
        while (calls_taken != calls_queued || outcome_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_hard_limit(input logic [LIMIT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        hard_limit <= v;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        cfg_valid <= 1'b0;
        hard_now = int'(v);
        limit_now = int'(v);
    endtask

    logic [LIMIT_W-1:0] hard_set [0:6];
    logic [TIME_W-1:0]  wall_us;
    logic [CMD_W-1:0]   pick_cmd;
    logic [PCT_W-1:0]   pick_pct;
    int                 step_max;
    int                 sel;

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty log, wrapping ages, exact window edge, unused command
        offer(CMD_READ_PEAK, '0, '0);
        offer(CMD_ATTEMPT, '0, 10'd1000);
        offer(CMD_ATTEMPT, '1, '0);
        offer(CMD_ATTEMPT, '0, '0);
        offer(CMD_ATTEMPT, TIME_W'(WINDOW_US - 1), '0);
        offer(CMD_ATTEMPT, WINDOW_US, '0);
        offer(CMD_UNUSED, WINDOW_US, 10'd5);
        offer(CMD_SOFT, WINDOW_US, '0);
        offer(CMD_SOFT, WINDOW_US, 10'd1000);
        for (int i = 0; i < 12; i++)
            offer(CMD_ATTEMPT, WINDOW_US + 48'd100, '0);
        offer(CMD_READ_PEAK, WINDOW_US + 48'd200, '0);
        offer(CMD_READ_PEAK, WINDOW_US + 48'd300, '0);
        offer(CMD_SOFT, WINDOW_US + 48'd400, '0);
        // time running backwards expires the whole log
        offer(CMD_ATTEMPT, 48'd50, '0);
        wait_drained(8);

        hard_set[0] = 16'hFFFF;
        hard_set[1] = 16'd1;
        hard_set[2] = 16'd3;
        hard_set[3] = 16'd0;
        hard_set[4] = LIMIT_W'($urandom_range(2, 30));
        hard_set[5] = LIMIT_W'($urandom);
        hard_set[6] = 16'd7;

        wall_us = 48'd1000;
        for (int ph = 0; ph < 7; ph++)
        begin
            write_hard_limit(hard_set[ph]);
            case ($urandom_range(0, 2))
                0:       step_max = 5000;
                1:       step_max = 50000;
                default: step_max = 400000;
            endcase
            if (ph == 2)
                hold_asked++;
            // run one phase across the top of the time range
            if (ph == 4)
                wall_us = 48'hFFFF_FFF0_0000;
            for (int i = 0; i < 72; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 80)
                    wall_us = wall_us + TIME_W'($urandom_range(0, step_max));
                else if (sel < 88)
                    wall_us = wall_us + WINDOW_US - 48'd2 + TIME_W'($urandom_range(0, 4));
                else if (sel < 95)
                    wall_us = wall_us - TIME_W'($urandom_range(1, 100000));
                else
                    wall_us = TIME_W'({$urandom, $urandom});
                sel = $urandom_range(0, 99);
                if (sel < 72)
                    pick_cmd = CMD_ATTEMPT;
                else if (sel < 84)
                    pick_cmd = CMD_SOFT;
                else if (sel < 94)
                    pick_cmd = CMD_READ_PEAK;
                else
                    pick_cmd = CMD_UNUSED;
                if (pick_cmd == CMD_SOFT && $urandom_range(0, 3) == 0)
                    pick_pct = '0;
                else
                    pick_pct = PCT_W'($urandom_range(0, 1000));
                offer(pick_cmd, wall_us, pick_pct);
            end
            // hold the sender until every result is back
            wait_drained(8);
        end

        // offer more attempts than the log holds, then expire all of it in one word
        write_hard_limit('0);
        wall_us = wall_us + 48'd12345;
        for (int i = 0; i < FIFO_DEPTH + 6; i++)
            offer(CMD_ATTEMPT, wall_us, '0);
        offer(CMD_SOFT, wall_us, 10'd1000);
        offer(CMD_ATTEMPT, wall_us + 48'd1, '0);
        offer(CMD_SOFT, wall_us + 48'd2, 10'd1);
        offer(CMD_READ_PEAK, wall_us + 48'd3, '0);
        offer(CMD_ATTEMPT, wall_us + WINDOW_US, '0);
        offer(CMD_READ_PEAK, wall_us + WINDOW_US, '0);

        wait_drained(DRAIN_CYCLES);
        if (fail_count == 0 && outcome_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/swrl_pkg.sv
rtl/sliding_window_call_rate_limiter.sv
tb/tb_top.sv
